// File: rtl/wpp_pkg.sv
package wpp_pkg;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_EXPECTED_RATE = 3'd0;
    localparam logic [31:0] EXPECTED_RATE_RESET = 32'd44100;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_RIFF      = 4'd1;
    localparam logic [3:0] ERR_WAVE      = 4'd2;
    localparam logic [3:0] ERR_FMT       = 4'd3;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd4;
    localparam logic [3:0] ERR_DATA_TAG  = 4'd5;
    localparam logic [3:0] ERR_RATE      = 4'd6;
    localparam logic [3:0] ERR_BITS      = 4'd7;
    localparam logic [3:0] ERR_ZERO_CHAN = 4'd8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         error_code;
        logic signed [15:0] sample_value;
        logic               to_left;
        logic               to_right;
        logic               last_sample;
        logic [15:0]        channel_count;
        logic [4:0]         sample_bits;
        logic [31:0]        data_bytes;
    } result_t;

endpackage

// File: rtl/wpp_cfg.sv
module wpp_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [31:0]                expected_rate
);

    logic [31:0] rate_reg;
    logic [31:0] rate_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        rate_next = rate_reg;
        if (wr_en)
        begin
            unique case (paddr)
                wpp_pkg::ADDR_EXPECTED_RATE: rate_next = pwdata;
                default: rate_next = rate_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            wpp_pkg::ADDR_EXPECTED_RATE: prdata = rate_reg;
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= wpp_pkg::EXPECTED_RATE_RESET;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    assign expected_rate = rate_reg;

endmodule

// File: rtl/wpp_core.sv
module wpp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       file_byte,
    input  logic             first_byte,
    input  logic [31:0]      expected_rate,
    output logic             res_valid,
    output wpp_pkg::result_t res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [5:0] POS_RIFF  = 6'd3;
    localparam logic [5:0] POS_WAVE  = 6'd11;
    localparam logic [5:0] POS_FMT   = 6'd15;
    localparam logic [5:0] POS_PCM   = 6'd21;
    localparam logic [5:0] POS_CHAN  = 6'd23;
    localparam logic [5:0] POS_RATE  = 6'd27;
    localparam logic [5:0] POS_BITS  = 6'd35;
    localparam logic [5:0] POS_DATA  = 6'd39;
    localparam logic [5:0] POS_SIZE  = 6'd43;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] idx_reg, idx_next;

    logic [1:0]  ph;
    logic [5:0]  pos;
    logic [31:0] shift;
    logic [16:0] idx_inc;
    logic        is_8bit;

    assign ph      = first_byte ? PH_HEAD : phase_reg;
    assign pos     = first_byte ? 6'd0 : pos_reg;
    assign shift   = first_byte ? 32'd0 : shift_reg;
    assign idx_inc = {1'b0, idx_reg} + 17'd1;
    assign is_8bit = (bits_reg == 16'd8);

    always_comb
    begin
        phase_next = ph;
        pos_next   = pos;
        shift_next = shift;
        chan_next  = chan_reg;
        bits_next  = bits_reg;
        rate_next  = rate_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        idx_next   = idx_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (ph)
            PH_HEAD:
            begin
                shift_next = {file_byte, shift[31:8]};
                pos_next   = pos + 6'd1;
                case (pos)
                    POS_RIFF:
                        if (shift_next != TAG_RIFF)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = wpp_pkg::ERR_RIFF;
                        end
                    POS_WAVE:
                        if (shift_next != TAG_WAVE)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = wpp_pkg::ERR_WAVE;
                        end
                    POS_FMT:
                        if (shift_next != TAG_FMT)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = wpp_pkg::ERR_FMT;
                        end
                    POS_PCM:
                        if (shift_next[31:16] != 16'd1)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = wpp_pkg::ERR_NOT_PCM;
                        end
                    POS_CHAN: chan_next = shift_next[31:16];
                    POS_RATE: rate_next = shift_next;
                    POS_BITS: bits_next = shift_next[31:16];
                    POS_DATA:
                        if (shift_next != TAG_DATA)
                        begin
                            res_valid      = 1'b1;
                            res.error_code = wpp_pkg::ERR_DATA_TAG;
                        end
                    POS_SIZE:
                    begin
                        rem_next  = shift_next;
                        res_valid = 1'b1;
                        // checks in priority order: rate, width, channels
                        if (rate_reg != expected_rate)
                            res.error_code = wpp_pkg::ERR_RATE;
                        else if (bits_reg != 16'd8 && bits_reg != 16'd16)
                            res.error_code = wpp_pkg::ERR_BITS;
                        else if (chan_reg == 16'd0)
                            res.error_code = wpp_pkg::ERR_ZERO_CHAN;
                    end
                    default: ;
                endcase
                if (res_valid)
                begin
                    if (res.error_code != wpp_pkg::ERR_NONE)
                    begin
                        res.kind   = wpp_pkg::KIND_ERROR;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res.kind          = wpp_pkg::KIND_HEADER;
                        res.channel_count = chan_reg;
                        res.sample_bits   = bits_reg[4:0];
                        res.data_bytes    = shift_next;
                        phase_next        = PH_DATA;
                        pos_next          = 6'd0;
                        idx_next          = 16'd0;
                        low_next          = 8'd0;
                    end
                end
                else if (pos_next > POS_SIZE)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DATA:
            begin
                if (rem_reg != 32'd0)
                begin
                    rem_next = rem_reg - 32'd1;
                    if (!is_8bit && !pos[0])
                    begin
                        // hold the low byte of a 16-bit sample
                        low_next = file_byte;
                        pos_next = 6'd1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.kind  = wpp_pkg::KIND_SAMPLE;
                        if (is_8bit)
                        begin
                            res.sample_value = {file_byte ^ 8'h80, 8'h00};
                            res.last_sample  = (rem_next == 32'd0);
                        end
                        else
                        begin
                            pos_next         = 6'd0;
                            res.sample_value = {file_byte, low_reg};
                            res.last_sample  = (rem_next < 32'd2);
                        end
                        if (chan_reg == 16'd1)
                        begin
                            res.to_left  = 1'b1;
                            res.to_right = 1'b1;
                        end
                        else
                        begin
                            res.to_left  = (idx_reg == 16'd0);
                            res.to_right = (idx_reg != 16'd0);
                        end
                        if (idx_inc >= {1'b0, chan_reg})
                            idx_next = 16'd0;
                        else
                            idx_next = idx_inc[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 6'd0;
            shift_reg <= 32'd0;
            chan_reg  <= 16'd0;
            bits_reg  <= 16'd0;
            rate_reg  <= 32'd0;
            rem_reg   <= 32'd0;
            low_reg   <= 8'd0;
            idx_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            chan_reg  <= chan_next;
            bits_reg  <= bits_next;
            rate_reg  <= rate_next;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: rtl/wav_pcm_stream_parser.sv
// a byte waits in the input register; its result is registered when the parser steps on it
// throughput: one byte per cycle; an input register and a result register part
// the two channels, so the parser steps whenever the result slot is free or draining
// bytes that give no result (ignored bytes, low halves of 16-bit samples) step at the same rate
// reset: asynchronous active low; parser idle until a first byte, expected rate 44100
module wav_pcm_stream_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 file_byte,
    input  logic                       first_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [3:0]                 error_code,
    output logic signed [15:0]         sample_value,
    output logic                       to_left,
    output logic                       to_right,
    output logic                       last_sample,
    output logic [15:0]                channel_count,
    output logic [4:0]                 sample_bits,
    output logic [31:0]                data_bytes
);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             first_reg;
    logic             out_vld_reg;
    wpp_pkg::result_t res_reg;
    wpp_pkg::result_t core_res;
    logic             core_res_valid;
    logic             step;
    logic [31:0]      expected_rate;

    wpp_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .expected_rate (expected_rate)
    );

    // the held byte is processed once the result slot can take its result
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;

    wpp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .file_byte     (byte_reg),
        .first_byte    (first_reg),
        .expected_rate (expected_rate),
        .res_valid     (core_res_valid),
        .res           (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (step)
                out_vld_reg <= core_res_valid;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= file_byte;
            first_reg <= first_byte;
        end
        if (step && core_res_valid)
            res_reg <= core_res;
    end

    assign out_valid     = out_vld_reg;
    assign kind          = res_reg.kind;
    assign error_code    = res_reg.error_code;
    assign sample_value  = res_reg.sample_value;
    assign to_left       = res_reg.to_left;
    assign to_right      = res_reg.to_right;
    assign last_sample   = res_reg.last_sample;
    assign channel_count = res_reg.channel_count;
    assign sample_bits   = res_reg.sample_bits;
    assign data_bytes    = res_reg.data_bytes;

    // an error result always carries a cause, other results none
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == wpp_pkg::KIND_ERROR |-> error_code != wpp_pkg::ERR_NONE)
        else $error("error result without a cause");

    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != wpp_pkg::KIND_ERROR |-> error_code == wpp_pkg::ERR_NONE)
        else $error("non-error result carries an error code");

    // every sample is routed to at least one track
    a_routed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == wpp_pkg::KIND_SAMPLE |-> to_left || to_right)
        else $error("sample with no track");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == wpp_pkg::KIND_HEADER
        |-> channel_count != 16'd0 && (sample_bits == 5'd8 || sample_bits == 5'd16))
        else $error("accepted header with bad format fields");

    // a stalled result slot must block the parser
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !step)
        else $error("parser stepped over a pending result");

endmodule

// File: test/tb_wav_pcm_stream_parser.sv
module tb_wav_pcm_stream_parser;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_DATA} parse_phase_t;

    class wav_scoreboard;
        wpp_pkg::result_t pending[$];
        int           mismatches;
        int           n_samples;
        int           n_headers;
        int           n_errors;
        logic [31:0]  rate_cfg;
        parse_phase_t phase;
        logic [5:0]   byte_pos;
        logic [31:0]  shift_reg;
        logic [15:0]  chans_seen;
        logic [15:0]  bits_seen;
        logic [31:0]  rate_seen;
        logic [31:0]  remaining;
        logic [7:0]   low_byte;
        logic [15:0]  chan_idx;

        function new();
            mismatches = 0;
            n_samples  = 0;
            n_headers  = 0;
            n_errors   = 0;
            rate_cfg   = wpp_pkg::EXPECTED_RATE_RESET;
            phase      = PARSE_IDLE;
            byte_pos   = '0;
            shift_reg  = '0;
            chans_seen = '0;
            bits_seen  = '0;
            rate_seen  = '0;
            remaining  = '0;
            low_byte   = '0;
            chan_idx   = '0;
        endfunction

        // returns 1 when the byte was consumed by the parser
        function bit note_byte(logic [7:0] value, logic start);
            wpp_pkg::result_t res;
            logic [5:0] pos;
            logic [3:0] err;
            logic [15:0] word;
            logic [1:0] width_bytes;
            bit         emit;
            bit         have;
            bit         used;
            res  = '0;
            err  = wpp_pkg::ERR_NONE;
            emit = 0;
            have = 0;
            used = 0;
            word = '0;
            width_bytes = 2'd1;
            if (start)
            begin
                phase     = PARSE_HEADER;
                byte_pos  = '0;
                shift_reg = '0;
            end
            if (phase == PARSE_HEADER)
            begin
                used      = 1;
                pos       = byte_pos;
                shift_reg = {value, shift_reg[31:8]};
                byte_pos  = pos + 6'd1;
                case (pos)
                    6'd3:  if (shift_reg != TAG_RIFF) err = wpp_pkg::ERR_RIFF;
                    6'd11: if (shift_reg != TAG_WAVE) err = wpp_pkg::ERR_WAVE;
                    6'd15: if (shift_reg != TAG_FMT) err = wpp_pkg::ERR_FMT;
                    6'd21: if (shift_reg[31:16] != 16'd1) err = wpp_pkg::ERR_NOT_PCM;
                    6'd23: chans_seen = shift_reg[31:16];
                    6'd27: rate_seen = shift_reg;
                    6'd35: bits_seen = shift_reg[31:16];
                    6'd39: if (shift_reg != TAG_DATA) err = wpp_pkg::ERR_DATA_TAG;
                    6'd43:
                    begin
                        remaining = shift_reg;
                        if (rate_seen != rate_cfg)
                            err = wpp_pkg::ERR_RATE;
                        else if (bits_seen != 16'd8 && bits_seen != 16'd16)
                            err = wpp_pkg::ERR_BITS;
                        else if (chans_seen == 16'd0)
                            err = wpp_pkg::ERR_ZERO_CHAN;
                        else
                        begin
                            phase             = PARSE_DATA;
                            byte_pos          = '0;
                            chan_idx          = '0;
                            low_byte          = '0;
                            res.kind          = wpp_pkg::KIND_HEADER;
                            res.channel_count = chans_seen;
                            res.sample_bits   = bits_seen[4:0];
                            res.data_bytes    = remaining;
                            emit              = 1;
                        end
                    end
                    default: ;
                endcase
                if (err != wpp_pkg::ERR_NONE)
                begin
                    phase          = PARSE_IDLE;
                    res.kind       = wpp_pkg::KIND_ERROR;
                    res.error_code = err;
                    emit           = 1;
                end
                else if (byte_pos > 6'd43)
                    phase = PARSE_IDLE;
            end
            else if (phase == PARSE_DATA && remaining != 32'd0)
            begin
                used      = 1;
                remaining = remaining - 32'd1;
                if (bits_seen == 16'd8)
                begin
                    word = {value ^ 8'h80, 8'h00};
                    have = 1;
                end
                else if (byte_pos[0] == 1'b0)
                begin
                    low_byte = value;
                    byte_pos = 6'd1;
                end
                else
                begin
                    byte_pos    = '0;
                    word        = {value, low_byte};
                    width_bytes = 2'd2;
                    have        = 1;
                end
                if (have)
                begin
                    // mono feeds both tracks, otherwise channel 0 left and the rest right
                    if (chans_seen == 16'd1)
                    begin
                        res.to_left  = 1'b1;
                        res.to_right = 1'b1;
                    end
                    else
                    begin
                        res.to_left  = (chan_idx == 16'd0);
                        res.to_right = (chan_idx != 16'd0);
                    end
                    chan_idx = chan_idx + 16'd1;
                    if (chan_idx >= chans_seen)
                        chan_idx = '0;
                    res.kind         = wpp_pkg::KIND_SAMPLE;
                    res.sample_value = word;
                    res.last_sample  = (remaining < {30'd0, width_bytes});
                    emit             = 1;
                end
            end
            if (emit)
                pending.push_back(res);
            return used;
        endfunction

        function void check_result(wpp_pkg::result_t got);
            wpp_pkg::result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result: kind=%0d err=%0d val=%0d l=%0b r=%0b",
                              " last=%0b ch=%0d bits=%0d bytes=%0d"},
                             got.kind, got.error_code, got.sample_value, got.to_left,
                             got.to_right, got.last_sample, got.channel_count,
                             got.sample_bits, got.data_bytes);
                return;
            end
            want = pending.pop_front();
            case (want.kind)
                wpp_pkg::KIND_SAMPLE: n_samples++;
                wpp_pkg::KIND_HEADER: n_headers++;
                default:              n_errors++;
            endcase
            if (got.kind !== want.kind || got.error_code !== want.error_code ||
                got.sample_value !== want.sample_value || got.to_left !== want.to_left ||
                got.to_right !== want.to_right || got.last_sample !== want.last_sample ||
                got.channel_count !== want.channel_count ||
                got.sample_bits !== want.sample_bits || got.data_bytes !== want.data_bytes)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"mismatch expected: kind=%0d err=%0d val=%0d l=%0b r=%0b",
                              " last=%0b ch=%0d bits=%0d bytes=%0d"},
                             want.kind, want.error_code, want.sample_value, want.to_left,
                             want.to_right, want.last_sample, want.channel_count,
                             want.sample_bits, want.data_bytes);
                    $display({"         actual:   kind=%0d err=%0d val=%0d l=%0b r=%0b",
                              " last=%0b ch=%0d bits=%0d bytes=%0d"},
                             got.kind, got.error_code, got.sample_value, got.to_left,
                             got.to_right, got.last_sample, got.channel_count,
                             got.sample_bits, got.data_bytes);
                end
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [wpp_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic [7:0]                 file_byte;
    logic                       first_byte;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 kind;
    logic [3:0]                 error_code;
    logic signed [15:0]         sample_value;
    logic                       to_left;
    logic                       to_right;
    logic                       last_sample;
    logic [15:0]                channel_count;
    logic [4:0]                 sample_bits;
    logic [31:0]                data_bytes;

    wav_scoreboard sb;
    logic [7:0]    hdr [44];
    int            cycle_count = 0;
    int            bytes_sent = 0;
    int            bytes_used = 0;
    bit            tx_burst = 0;
    bit            hold_go = 0;
    logic          long_hold = 1'b0;

    wav_pcm_stream_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .file_byte    (file_byte),
        .first_byte   (first_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .error_code   (error_code),
        .sample_value (sample_value),
        .to_left      (to_left),
        .to_right     (to_right),
        .last_sample  (last_sample),
        .channel_count(channel_count),
        .sample_bits  (sample_bits),
        .data_bytes   (data_bytes)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_count);
        $display("wav_pcm_stream_parser regression: fail");
        $finish;
    end

    // receiver: random stalls per result, plus the long hold-off when asked
    initial
    begin
        int rx_wait;
        bit rx_burst;
        rx_wait   = 0;
        rx_burst  = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            out_ready <= (rx_wait == 0) && !long_hold;
            if (rx_wait > 0)
                rx_wait--;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result({kind, error_code, sample_value, to_left, to_right,
                                 last_sample, channel_count, sample_bits, data_bytes});
                if ($urandom_range(0, 63) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
            end
        end
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // all driving tasks start and end on a falling edge
    task automatic send_byte(input logic [7:0] value, input logic start);
        int gap;
        if ($urandom_range(0, 99) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        file_byte  <= value;
        first_byte <= start;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (sb.note_byte(value, start))
            bytes_used++;
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic put_word(input int at, input logic [31:0] value);
        for (int k = 0; k < 4; k++)
            hdr[at + k] = value[8*k +: 8];
    endtask

    task automatic build_header(input logic [15:0] chans, input logic [31:0] rate,
                                input logic [15:0] width, input logic [31:0] size);
        put_word(0, TAG_RIFF);
        put_word(4, $urandom);
        put_word(8, TAG_WAVE);
        put_word(12, TAG_FMT);
        put_word(16, ($urandom_range(0, 3) == 0) ? $urandom : 32'd16);
        put_word(20, {chans, 16'd1});
        put_word(24, rate);
        put_word(28, $urandom);
        put_word(32, {width, 16'($urandom)});
        put_word(36, TAG_DATA);
        put_word(40, size);
    endtask

    task automatic send_header(input int count);
        for (int i = 0; i < count; i++)
            send_byte(hdr[i], i == 0);
    endtask

    task automatic send_data(input int count);
        repeat (count) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_rate(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= wpp_pkg::ADDR_EXPECTED_RATE;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.rate_cfg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly well-formed files with random content, some broken, some noise
    task automatic random_traffic(input int amount);
        int          goal;
        int          pick;
        int          sel;
        int          n;
        logic [15:0] ch;
        logic [15:0] wb;
        logic [31:0] rt;
        logic [31:0] sz;
        goal = bytes_used + amount;
        while (bytes_used < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 8)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
            end
            else
            begin
                sel = $urandom_range(0, 19);
                if (sel < 8)
                    ch = 16'd1;
                else if (sel < 14)
                    ch = 16'd2;
                else if (sel < 17)
                    ch = 16'($urandom_range(3, 6));
                else if (sel == 17)
                    ch = 16'hFFFF;
                else if (sel == 18)
                    ch = 16'($urandom);
                else
                    ch = 16'd0;
                sel = $urandom_range(0, 9);
                wb  = (sel < 5) ? 16'd8 : (sel < 9) ? 16'd16 : 16'($urandom);
                rt  = ($urandom_range(0, 9) == 0) ? $urandom : sb.rate_cfg;
                sz  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
                build_header(ch, rt, wb, sz);
                if (pick == 7)
                    hdr[$urandom_range(0, 43)] ^= 8'($urandom_range(1, 255));
                if (pick == 9)
                    send_header($urandom_range(1, 43));
                else
                begin
                    send_header(44);
                    n = (sz > 32'd40) ? $urandom_range(0, 44) : $urandom_range(0, sz + 4);
                    send_data(n);
                end
            end
        end
    endtask

    initial
    begin
        logic [31:0] rate_plan [5];
        sb         = new();
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        file_byte  = '0;
        first_byte = 1'b0;
        rate_plan  = '{32'hFFFF_FFFF, 32'd0, $urandom, 32'd48000,
                       wpp_pkg::EXPECTED_RATE_RESET};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes before any file start are dropped
        send_byte(8'h52, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // mono 8-bit with extreme bytes, then bytes beyond the data size
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd5);
        send_header(44);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);

        // stereo 16-bit with a lone trailing byte
        build_header(16'd2, wpp_pkg::EXPECTED_RATE_RESET, 16'd16, 32'd9);
        send_header(44);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);

        // three channels, cut short by a new file
        build_header(16'd3, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd6);
        send_header(44);
        send_data(4);

        // widest channel count and data size
        build_header(16'hFFFF, wpp_pkg::EXPECTED_RATE_RESET, 16'd16, 32'hFFFF_FFFF);
        send_header(44);
        send_data(6);

        // empty data chunk
        build_header(16'd2, wpp_pkg::EXPECTED_RATE_RESET, 16'd16, 32'd0);
        send_header(44);
        send_data(3);

        // restart in the middle of a header
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        send_header(20);
        send_header(44);
        send_data(4);

        // one failing check per file, each followed by an ignored byte
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        hdr[2] ^= 8'h01;
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        hdr[11] ^= 8'h20;
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        hdr[15] ^= 8'hFF;
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        hdr[21] = 8'h01;
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd8, 32'd4);
        hdr[36] ^= 8'h40;
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET + 32'd1, 16'd8, 32'd4);
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd1, wpp_pkg::EXPECTED_RATE_RESET, 16'd12, 32'd4);
        send_header(44);
        send_byte(8'hA5, 1'b0);
        build_header(16'd0, wpp_pkg::EXPECTED_RATE_RESET, 16'd16, 32'd4);
        send_header(44);
        send_byte(8'hA5, 1'b0);

        wait_idle();
        for (int p = 0; p < 5; p++)
        begin
            write_rate(rate_plan[p]);
            if (p == 2)
                hold_go = 1;
            random_traffic(40);
            wait_idle();
        end

        $display("covered %0d byte transactions (%0d parsed): %0d headers, %0d errors, %0d samples",
                 bytes_sent, bytes_used, sb.n_headers, sb.n_errors, sb.n_samples);
        $display("five rate settings incl. zero and all ones, one long output stall; %0d mismatches",
                 sb.mismatches);
        if (sb.pending.size() != 0)
            $display("%0d results never arrived", sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("wav_pcm_stream_parser regression: pass");
        else
            $display("wav_pcm_stream_parser regression: fail");
        $finish;
    end

endmodule
